@@ hdl/cwat_pkg.sv @@
// ============================================================================
// cwat_pkg - shared types and constants for the current window average trip
// Field widths, configuration register codes and reset values, output queue
// sizing, and the structs passed between the pipeline modules.
// ============================================================================
`default_nettype none

package cwat_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int AVG_W       = 12;
    localparam int THRESH_W    = 12;
    localparam int INTERVAL_W  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL  = 1'b1;

    localparam logic [THRESH_W-1:0]   THRESH_RESET   = 12'd4095;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd200;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    typedef struct packed {
        logic valid;
        logic report;
    } cwat_tag_t;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic             trip;
        logic             report;
    } cwat_result_t;

endpackage

`default_nettype wire

@@ hdl/cwat_if.sv @@
// ============================================================================
// cwat_if - request channels of the current window average trip
// Sample channel into the block and result channel out of it, each with
// valid/ready handshake and its payload.
// ============================================================================
`default_nettype none

interface cwat_sample_if;
    import cwat_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cwat_result_if;
    import cwat_pkg::*;

    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic             trip;
    logic             report;

    modport source (output valid, output average, output trip, output report, input ready);
    modport sink   (input valid, input average, input trip, input report, output ready);
endinterface

`default_nettype wire

@@ hdl/cwat_ring_mem.sv @@
// ============================================================================
// cwat_ring_mem - sample ring storage
// Single write port, single read port, read data registered.
// ============================================================================
`default_nettype none

module cwat_ring_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 12,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/cwat_scale.sv @@
// ============================================================================
// cwat_scale - window sum to average and trip decision
// Divide by the window length as a multiply by a rounded-up reciprocal, then
// take the high bits and compare against the trip threshold.
// ============================================================================
`default_nettype none

module cwat_scale #(
    parameter int WINDOW = 256,
    parameter int SUM_W  = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cwat_pkg::cwat_tag_t            tag,
    input  logic [SUM_W-1:0]               sum,
    input  logic [cwat_pkg::THRESH_W-1:0]  threshold,
    output logic                           push,
    output cwat_pkg::cwat_result_t         push_data
);
    import cwat_pkg::*;

    // Exact for every sum below 2**SUM_W with shift = SUM_W + ceil(log2(WINDOW))
    localparam int          SHIFT      = SUM_W + $clog2(WINDOW);
    localparam int          RECIP_W    = SUM_W + 2;
    localparam int          PROD_W     = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                         / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    cwat_tag_t          tag_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [AVG_W-1:0]   average;

    assign prod_next = PROD_W'(sum) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign average           = AVG_W'(prod_reg >> SHIFT);
    assign push              = tag_reg.valid;
    assign push_data.average = average;
    assign push_data.trip    = (average > threshold);
    assign push_data.report  = tag_reg.report;

endmodule

`default_nettype wire

@@ hdl/cwat_out_queue.sv @@
// ============================================================================
// cwat_out_queue - result queue
// Hold finished results until the sink takes them; the top level keeps the
// number of outstanding requests within the queue depth.
// ============================================================================
`default_nettype none

module cwat_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cwat_pkg::cwat_result_t push_data,
    input  logic                   pop,
    output logic                   valid,
    output cwat_pkg::cwat_result_t data
);
    import cwat_pkg::*;

    cwat_result_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   head_next;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QPTR_W-1:0]   tail_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                take;

    assign valid = (count_reg != '0);
    assign take  = pop && valid;
    assign data  = entry_reg[head_reg];

    always_comb
    begin
        head_next  = take ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        case ({push, take})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/current_window_average_trip.sv @@
// Pipeline: ring read, sum update and ring write-back, reciprocal multiply,
//   queue, in that order, for each accepted sample request.
// Throughput: one sample per cycle while the queue has room; reading slot n
//   and writing back slot n-1 always differ: no interlock is needed.
// Reset: the ring reads as zero until the write index first wraps, the sum,
//   index and report count clear, threshold 4095, report interval 200.
// ============================================================================
// current_window_average_trip - boxcar moving average overcurrent trip
// Keep the last WINDOW samples in a ring memory with a running sum, report
// the window average, a trip flag when it exceeds the threshold, and a
// report flag every report_interval samples.
// ============================================================================
`default_nettype none

module current_window_average_trip #(
    parameter int WINDOW      = 256,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cwat_sample_if.sink                       sample_ch,
    cwat_result_if.source                     result_ch,
    input  logic                              cfg_we,
    input  logic [cwat_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cwat_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cwat_pkg::*;

    // Bits of a sample that survive the field width and the sample mask
    localparam int EFF_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int RING_W = SAMPLE_BITS;
    localparam int SUM_W  = EFF_W + ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0]   thresh_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESH_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thresh_reg   <= cfg_data[THRESH_W-1:0];
                CFG_INTERVAL:  interval_reg <= cfg_data[INTERVAL_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: issue the ring read of the oldest slot, advance the
    // write index and the report counter.
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  deliver;
    logic [QCNT_W-1:0]     occ_reg;
    logic [QCNT_W-1:0]     occ_next;
    logic [ADDR_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]     idx_next;
    logic                  wrapped_reg;
    logic                  wrapped_next;
    logic [INTERVAL_W-1:0] count_reg;
    logic [INTERVAL_W-1:0] count_inc;
    logic [INTERVAL_W-1:0] count_next;
    logic                  report_hit;
    logic [RING_W-1:0]     sample_masked;

    // Allow new requests while the results in flight fit in the queue
    assign sample_ch.ready = (occ_reg < QCNT_W'(QUEUE_DEPTH));
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign deliver         = result_ch.valid && result_ch.ready;
    assign sample_masked   = RING_W'(sample_ch.sample[EFF_W-1:0]);

    assign count_inc  = count_reg + 1'b1;
    assign report_hit = (count_inc >= interval_reg);

    always_comb
    begin
        idx_next     = idx_reg;
        wrapped_next = wrapped_reg;
        count_next   = count_reg;
        if (accept)
        begin
            if (idx_reg == ADDR_W'(WINDOW - 1))
            begin
                idx_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
            count_next = report_hit ? '0 : count_inc;
        end
    end

    always_comb
    begin
        case ({accept, deliver})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    // Stage 1 registers: sample and slot waiting for the ring read data
    logic              s1_valid_reg;
    logic [RING_W-1:0] s1_sample_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_fresh_reg;
    logic              s1_report_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            idx_reg      <= '0;
            wrapped_reg  <= 1'b0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            idx_reg      <= idx_next;
            wrapped_reg  <= wrapped_next;
            count_reg    <= count_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_masked;
            s1_addr_reg   <= idx_reg;
            // Slot not yet written since reset reads as zero
            s1_fresh_reg  <= !wrapped_reg;
            s1_report_reg <= report_hit;
        end
    end

    // ------------------------------------------------------------------
    // Ring memory and running sum: drop the oldest entry, add the new
    // sample, write the sample back into the same slot.
    // ------------------------------------------------------------------
    logic [RING_W-1:0] rd_data;
    logic [RING_W-1:0] old_val;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    cwat_tag_t         s2_tag_reg;

    cwat_ring_mem #(
        .DEPTH  (WINDOW),
        .DATA_W (RING_W),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_sample_reg)
    );

    assign old_val  = s1_fresh_reg ? '0 : rd_data;
    assign sum_next = s1_valid_reg
                    ? sum_reg - SUM_W'(old_val) + SUM_W'(s1_sample_reg)
                    : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            sum_reg           <= sum_next;
            s2_tag_reg.valid  <= s1_valid_reg;
            s2_tag_reg.report <= s1_report_reg;
        end
    end

    // ------------------------------------------------------------------
    // Average, trip compare and result queue
    // ------------------------------------------------------------------
    logic         push;
    cwat_result_t push_data;
    cwat_result_t head_data;

    cwat_scale #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (s2_tag_reg),
        .sum       (sum_reg),
        .threshold (thresh_reg),
        .push      (push),
        .push_data (push_data)
    );

    cwat_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (result_ch.ready),
        .valid     (result_ch.valid),
        .data      (head_data)
    );

    assign result_ch.average = head_data.average;
    assign result_ch.trip    = head_data.trip;
    assign result_ch.report  = head_data.report;

endmodule

`default_nettype wire

@@ hdl/cwat_checker.sv @@
// ============================================================================
// cwat_checker - port-level checks for the current window average trip
// Latency, queue-full and trip consistency as seen on the top-level ports.
// ============================================================================
`default_nettype none

module cwat_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [cwat_pkg::AVG_W-1:0]  out_average,
    input logic                        out_trip
);
    import cwat_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_trip))
        else $error("result changed while stalled");

    // Every accepted request is followed by a valid result at the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##4 out_valid)
        else $error("result missing four cycles after request");

    // Input backpressure only when results are waiting
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // A trip needs an average above some threshold
    a_trip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_trip |-> out_average != '0)
        else $error("trip with zero average");

endmodule

bind current_window_average_trip cwat_checker u_cwat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .out_average (result_ch.average),
    .out_trip    (result_ch.trip)
);

`default_nettype wire
